// ===== design/ocd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the occupied-from-cross-dilation block.
// No dependencies; used by the unit and by its testbench.
package ocd_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 64;
   localparam int unsigned MAX_HEIGHT_DEF = 64;
   localparam int unsigned MAX_DEPTH      = 1024;

   // register field widths and reset values
   localparam int unsigned WIDTH_W      = 7;
   localparam int unsigned HEIGHT_W     = 7;
   localparam int unsigned DEPTH_W      = 11;
   localparam int unsigned WIDTH_RESET  = 64;
   localparam int unsigned HEIGHT_RESET = 64;
   localparam int unsigned DEPTH_RESET  = 1;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH  = 2'd2;

   localparam int unsigned VOXEL_W = 8;
   localparam int unsigned OCC_W   = 10;

   typedef struct packed {
      logic [VOXEL_W-1:0] empty_value;
      logic [VOXEL_W-1:0] frontier_value;
      logic               flush;
   } req_type;

   typedef struct packed {
      logic signed [OCC_W-1:0] occupied_value;
      logic                    last_voxel;
   } rsp_type;

   // zero counts as one, anything above the limit as the limit
   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] value,
                                             input int unsigned hi);
      int unsigned v;
      v = int'(value);
      if (v < 1) begin
         clamp_dim = 1;
      end else if (v > hi) begin
         clamp_dim = hi;
      end else begin
         clamp_dim = v;
      end
   endfunction

endpackage

// ===== design/ocd_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module ocd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== design/occupied_from_cross_dilation_unit.sv =====
`timescale 1ns / 1ps
// Streaming 6-neighbour cross dilation of the empty map, minus empty and frontier.
// Depends on ocd_pkg and ocd_ram.
// Throughput: one beat per cycle while req_ready is high. A center's result is registered
//   via stage 1 after its +z neighbour's beat (one plane later) or a flush/drain beat.
// Window lives in two copies of a 2*max-plane+1 circular store, each with two read ports.
// Reset and every write to the width, height or depth register restart the volume and
//   hold req_ready low while the tap pointers are set up; the stores are not cleared.
module occupied_from_cross_dilation_unit #(
   parameter int unsigned MAX_WIDTH  = ocd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = ocd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  ocd_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ocd_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [ocd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ocd_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned CDW       = ocd_pkg::CSR_DATA_W;
   localparam int unsigned VW        = ocd_pkg::VOXEL_W;
   localparam int unsigned XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned ZW        = $clog2(ocd_pkg::MAX_DEPTH);
   localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW        = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned DW        = ocd_pkg::DEPTH_W;
   localparam int unsigned PLANE_CAP = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned PW        = $clog2(PLANE_CAP + 1);
   localparam int unsigned WIN_CAP   = 2 * PLANE_CAP + 1;
   localparam int unsigned AW        = $clog2(WIN_CAP);

   localparam int unsigned W_RST = (ocd_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                   MAX_WIDTH : ocd_pkg::WIDTH_RESET;
   localparam int unsigned H_RST = (ocd_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                   MAX_HEIGHT : ocd_pkg::HEIGHT_RESET;

   localparam logic [1:0] SETTLE_DONE  = 2'd0;
   localparam logic [1:0] SETTLE_LOAD  = 2'd1;
   localparam logic [1:0] SETTLE_START = 2'd2;

   typedef struct packed {
      logic xm;
      logic xp;
      logic ym;
      logic yp;
      logic zm;
      logic zp;
   } nbr_type;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] a);
      ptr_next = (a == AW'(WIN_CAP - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [VW-1:0] max8(input logic [VW-1:0] a, input logic [VW-1:0] b);
      max8 = (a > b) ? a : b;
   endfunction

   // configuration, stored already clamped
   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [DW-1:0] d_ff, d_in;
   logic [PW-1:0] plane_ff;
   logic          cfg_hit;
   logic [1:0]    settle_ff, settle_in;

   // input and center coordinates
   logic [XW-1:0] ix_ff, ix_in, cx_ff, cx_in;
   logic [YW-1:0] iy_ff, iy_in, cy_ff, cy_in;
   logic [ZW-1:0] iz_ff, iz_in, cz_ff, cz_in;
   logic          in_done_ff, in_done_in;

   // tap pointers into the circular window, c = current center
   logic [AW-1:0] wp_ff, wp_in;     // c + plane, write slot
   logic [AW-1:0] a_c1_ff, a_c1_in; // c + 1
   logic [AW-1:0] a_pw_ff, a_pw_in; // c + w
   logic [AW-1:0] a_mw_ff, a_mw_in; // c - w
   logic [AW-1:0] a_mp_ff, a_mp_in; // c - plane

   logic req_fire, act, normal, emit;
   logic i_xe, i_ye, i_ze, c_xe, c_ye, c_ze, c_last;
   logic ram_rd_en, ram_wr_en;

   logic [2*VW-1:0] ram_a_rd_c1, ram_a_rd_pw;
   logic [VW-1:0]   ram_b_rd_mw, ram_b_rd_mp;

   // stage 1: window data returns from the stores
   logic            s1_valid_ff;
   logic            s1_emit_ff, s1_last_ff, s1_fwd_ff;
   nbr_type         s1_nbr_ff;
   logic [VW-1:0]   s1_ev_ff, s1_fv_ff;
   logic            s1_go;
   logic [2*VW-1:0] chain_in;
   logic [2*VW-1:0] h1_ff;           // {empty, frontier} at c
   logic [VW-1:0]   h0_ff;           // empty at c - 1
   logic [VW-1:0]   dil;
   logic signed [ocd_pkg::OCC_W-1:0] occ;

   logic             rsp_valid_ff, rsp_valid_in;
   ocd_pkg::rsp_type rsp_data_ff;

   // ---------------- configuration ----------------
   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      d_in    = d_ff;
      cfg_hit = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            ocd_pkg::REG_WIDTH: begin
               w_in    = WW'(ocd_pkg::clamp_dim(CDW'(csr_data[ocd_pkg::WIDTH_W-1:0]),
                                                MAX_WIDTH));
               cfg_hit = 1'b1;
            end
            ocd_pkg::REG_HEIGHT: begin
               h_in    = HW'(ocd_pkg::clamp_dim(CDW'(csr_data[ocd_pkg::HEIGHT_W-1:0]),
                                                MAX_HEIGHT));
               cfg_hit = 1'b1;
            end
            ocd_pkg::REG_DEPTH: begin
               d_in    = DW'(ocd_pkg::clamp_dim(csr_data, ocd_pkg::MAX_DEPTH));
               cfg_hit = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- accept side ----------------
   assign req_fire  = req_valid && req_ready;
   assign normal    = !in_done_ff && !req_data.flush;
   assign act       = in_done_ff || !req_data.flush;
   assign emit      = in_done_ff || (iz_ff != '0);
   assign ram_rd_en = req_fire && act;
   assign ram_wr_en = req_fire && normal;

   assign i_xe   = (WW'(ix_ff) + WW'(1)) == w_ff;
   assign i_ye   = (HW'(iy_ff) + HW'(1)) == h_ff;
   assign i_ze   = (DW'(iz_ff) + DW'(1)) == d_ff;
   assign c_xe   = (WW'(cx_ff) + WW'(1)) == w_ff;
   assign c_ye   = (HW'(cy_ff) + HW'(1)) == h_ff;
   assign c_ze   = (DW'(cz_ff) + DW'(1)) == d_ff;
   assign c_last = c_xe && c_ye && c_ze;

   always_comb begin
      settle_in  = settle_ff;
      ix_in      = ix_ff;
      iy_in      = iy_ff;
      iz_in      = iz_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      in_done_in = in_done_ff;
      wp_in      = wp_ff;
      a_c1_in    = a_c1_ff;
      a_pw_in    = a_pw_ff;
      a_mw_in    = a_mw_ff;
      a_mp_in    = a_mp_ff;
      if (cfg_hit) begin
         settle_in  = SETTLE_START;
         ix_in      = '0;
         iy_in      = '0;
         iz_in      = '0;
         cx_in      = '0;
         cy_in      = '0;
         cz_in      = '0;
         in_done_in = 1'b0;
      end else if (settle_ff == SETTLE_LOAD) begin
         // base the write slot at 2*plane so that no tap needs a wrap
         settle_in = SETTLE_DONE;
         wp_in     = AW'({plane_ff, 1'b0});
         a_c1_in   = AW'(plane_ff) + AW'(1);
         a_pw_in   = AW'(plane_ff) + AW'(w_ff);
         a_mw_in   = AW'(plane_ff) - AW'(w_ff);
         a_mp_in   = '0;
      end else if (settle_ff != SETTLE_DONE) begin
         settle_in = settle_ff - 1'b1;
      end else if (req_fire && act) begin
         if (normal) begin
            if (i_xe) begin
               ix_in = '0;
               if (i_ye) begin
                  iy_in = '0;
                  if (i_ze) begin
                     in_done_in = 1'b1;
                  end else begin
                     iz_in = iz_ff + 1'b1;
                  end
               end else begin
                  iy_in = iy_ff + 1'b1;
               end
            end else begin
               ix_in = ix_ff + 1'b1;
            end
         end
         if (emit) begin
            if (c_last) begin
               ix_in      = '0;
               iy_in      = '0;
               iz_in      = '0;
               cx_in      = '0;
               cy_in      = '0;
               cz_in      = '0;
               in_done_in = 1'b0;
            end else if (c_xe) begin
               cx_in = '0;
               if (c_ye) begin
                  cy_in = '0;
                  cz_in = cz_ff + 1'b1;
               end else begin
                  cy_in = cy_ff + 1'b1;
               end
            end else begin
               cx_in = cx_ff + 1'b1;
            end
         end
         wp_in   = ptr_next(wp_ff);
         a_c1_in = ptr_next(a_c1_ff);
         a_pw_in = ptr_next(a_pw_ff);
         a_mw_in = ptr_next(a_mw_ff);
         a_mp_in = ptr_next(a_mp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff       <= WW'(W_RST);
         h_ff       <= HW'(H_RST);
         d_ff       <= DW'(ocd_pkg::DEPTH_RESET);
         settle_ff  <= SETTLE_START;
         ix_ff      <= '0;
         iy_ff      <= '0;
         iz_ff      <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         cz_ff      <= '0;
         in_done_ff <= 1'b0;
         wp_ff      <= '0;
         a_c1_ff    <= '0;
         a_pw_ff    <= '0;
         a_mw_ff    <= '0;
         a_mp_ff    <= '0;
      end else begin
         w_ff       <= w_in;
         h_ff       <= h_in;
         d_ff       <= d_in;
         settle_ff  <= settle_in;
         ix_ff      <= ix_in;
         iy_ff      <= iy_in;
         iz_ff      <= iz_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         cz_ff      <= cz_in;
         in_done_ff <= in_done_in;
         wp_ff      <= wp_in;
         a_c1_ff    <= a_c1_in;
         a_pw_ff    <= a_pw_in;
         a_mw_ff    <= a_mw_in;
         a_mp_ff    <= a_mp_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= PW'(PW'(w_ff) * PW'(h_ff));
   end

   // ---------------- window stores ----------------
   // copy A: {empty, frontier}, reads c+1 and c+w; copy B: empty, reads c-w and c-plane
   ocd_ram #(
      .WIDTH (2 * VW),
      .DEPTH (WIN_CAP)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (wp_ff),
      .wr_data   ({req_data.empty_value, req_data.frontier_value}),
      .rd_en     (ram_rd_en),
      .rd_addr_a (a_c1_ff),
      .rd_addr_b (a_pw_ff),
      .rd_data_a (ram_a_rd_c1),
      .rd_data_b (ram_a_rd_pw)
   );

   ocd_ram #(
      .WIDTH (VW),
      .DEPTH (WIN_CAP)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (wp_ff),
      .wr_data   (req_data.empty_value),
      .rd_en     (ram_rd_en),
      .rd_addr_a (a_mw_ff),
      .rd_addr_b (a_mp_ff),
      .rd_data_a (ram_b_rd_mw),
      .rd_data_b (ram_b_rd_mp)
   );

   // ---------------- stage 1 ----------------
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = (settle_ff == SETTLE_DONE) && (!s1_valid_ff || s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= act;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && act) begin
         s1_emit_ff    <= emit;
         s1_last_ff    <= c_last;
         // 1x1 plane: c+1 is the slot written by this same beat
         s1_fwd_ff     <= (a_c1_ff == wp_ff);
         s1_ev_ff      <= req_data.empty_value;
         s1_fv_ff      <= req_data.frontier_value;
         s1_nbr_ff.xm  <= (cx_ff != '0);
         s1_nbr_ff.xp  <= !c_xe;
         s1_nbr_ff.ym  <= (cy_ff != '0);
         s1_nbr_ff.yp  <= !c_ye;
         s1_nbr_ff.zm  <= (cz_ff != '0);
         s1_nbr_ff.zp  <= !c_ze;
      end
   end

   assign chain_in = s1_fwd_ff ? {s1_ev_ff, s1_fv_ff} : ram_a_rd_c1;

   // c+1 of one beat is c of the next and c-1 of the one after
   always_ff @(posedge clock) begin
      if (s1_go) begin
         h1_ff <= chain_in;
         h0_ff <= h1_ff[2*VW-1:VW];
      end
   end

   always_comb begin
      dil = h1_ff[2*VW-1:VW];
      if (s1_nbr_ff.xm) begin
         dil = max8(dil, h0_ff);
      end
      if (s1_nbr_ff.xp) begin
         dil = max8(dil, chain_in[2*VW-1:VW]);
      end
      if (s1_nbr_ff.ym) begin
         dil = max8(dil, ram_b_rd_mw);
      end
      if (s1_nbr_ff.yp) begin
         dil = max8(dil, ram_a_rd_pw[2*VW-1:VW]);
      end
      if (s1_nbr_ff.zm) begin
         dil = max8(dil, ram_b_rd_mp);
      end
      if (s1_nbr_ff.zp) begin
         dil = max8(dil, s1_ev_ff);
      end
   end

   assign occ = $signed({2'b00, dil}) - $signed({2'b00, h1_ff[2*VW-1:VW]})
              - $signed({2'b00, h1_ff[VW-1:0]});

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_data_ff.occupied_value <= occ;
         rsp_data_ff.last_voxel     <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_settle_blocks: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != SETTLE_DONE) |-> !req_ready)
      else $error("beat accepted while tap pointers are being set up");

   a_stall_holds_reads: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> !ram_rd_en)
      else $error("store read issued while stage 1 is stalled");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && act && emit && c_last) |=>
      (!in_done_ff && cx_ff == '0 && cy_ff == '0 && cz_ff == '0 && iz_ff == '0))
      else $error("volume counters not cleared after the last voxel");
`endif

endmodule

// ===== tb/sv/tb_occupied_from_cross_dilation_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for occupied_from_cross_dilation_unit: streams voxel volumes,
// predicts every dilated occupancy beat with its own window model and checks the results.
// Depends on ocd_pkg and the block's RTL; needs no files or arguments.
module tb_occupied_from_cross_dilation_unit;

   localparam int unsigned VW            = ocd_pkg::VOXEL_W;
   localparam int unsigned CIW           = ocd_pkg::CSR_INDEX_W;
   localparam int unsigned CDW           = ocd_pkg::CSR_DATA_W;
   localparam int unsigned WREG_W        = ocd_pkg::WIDTH_W;
   localparam int unsigned HREG_W        = ocd_pkg::HEIGHT_W;
   localparam int unsigned DREG_W        = ocd_pkg::DEPTH_W;
   localparam int unsigned PLANE_CAP     = ocd_pkg::MAX_WIDTH_DEF * ocd_pkg::MAX_HEIGHT_DEF;
   localparam int unsigned WINDOW_CAP    = 2 * PLANE_CAP + 1;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam logic [CIW-1:0] REG_SPARE  = 2'd3;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   ocd_pkg::req_type          req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   ocd_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CIW-1:0]            csr_index = ocd_pkg::REG_WIDTH;
   logic [CDW-1:0]            csr_data  = '0;

   // predictor state
   bit [VW-1:0]               empty_window [WINDOW_CAP];
   bit [VW-1:0]               frontier_line [PLANE_CAP];
   logic [WREG_W-1:0]         width_reg  = WREG_W'(ocd_pkg::WIDTH_RESET);
   logic [HREG_W-1:0]         height_reg = HREG_W'(ocd_pkg::HEIGHT_RESET);
   logic [DREG_W-1:0]         depth_reg  = DREG_W'(ocd_pkg::DEPTH_RESET);
   int unsigned               voxels_in  = 0;
   int unsigned               ctr_x = 0, ctr_y = 0, ctr_z = 0;
   ocd_pkg::rsp_type          expected_occupancy [$];

   int unsigned send_idle_pct   = 0;
   int unsigned stall_pct       = 0;
   int unsigned beats_sent      = 0;
   int unsigned stream_items    = 0;
   int unsigned volumes_closed  = 0;
   int unsigned csr_writes      = 0;
   int unsigned results_checked = 0;
   int unsigned failures        = 0;
   int unsigned cycle_count     = 0;

   occupied_from_cross_dilation_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned dim_used(int unsigned raw, int unsigned hi);
      if (raw == 0) return 1;
      return (raw > hi) ? hi : raw;
   endfunction

   function automatic void active_dims(output int unsigned w, h, d);
      w = dim_used(width_reg, ocd_pkg::MAX_WIDTH_DEF);
      h = dim_used(height_reg, ocd_pkg::MAX_HEIGHT_DEF);
      d = dim_used(depth_reg, ocd_pkg::MAX_DEPTH);
   endfunction

   function automatic void restart_volume();
      voxels_in = 0;
      ctr_x = 0;
      ctr_y = 0;
      ctr_z = 0;
   endfunction

   function automatic void latch_register(logic [CIW-1:0] idx, logic [CDW-1:0] value);
      case (idx)
         ocd_pkg::REG_WIDTH: begin
            width_reg = value[WREG_W-1:0];
            restart_volume();
         end
         ocd_pkg::REG_HEIGHT: begin
            height_reg = value[HREG_W-1:0];
            restart_volume();
         end
         ocd_pkg::REG_DEPTH: begin
            depth_reg = value[DREG_W-1:0];
            restart_volume();
         end
         default: ;
      endcase
   endfunction

   function automatic int take_peak(int peak, int unsigned slot);
      int level;
      level = empty_window[slot % WINDOW_CAP];
      return (level > peak) ? level : peak;
   endfunction

   // result for the voxel at the center coordinates, then step the center on
   function automatic void emit_occupancy(logic [VW-1:0] frontier_level);
      int unsigned      w, h, d, plane, c;
      int               center_level, peak, front, occupancy;
      ocd_pkg::rsp_type beat;
      active_dims(w, h, d);
      plane = w * h;
      c = ctr_x + ctr_y * w + ctr_z * plane;
      center_level = empty_window[c % WINDOW_CAP];
      front = frontier_level;
      peak = center_level;
      if (ctr_x > 0)     peak = take_peak(peak, c + WINDOW_CAP - 1);
      if (ctr_x + 1 < w) peak = take_peak(peak, c + 1);
      if (ctr_y > 0)     peak = take_peak(peak, c + WINDOW_CAP - w);
      if (ctr_y + 1 < h) peak = take_peak(peak, c + w);
      if (ctr_z > 0)     peak = take_peak(peak, c + WINDOW_CAP - plane);
      if (ctr_z + 1 < d) peak = take_peak(peak, c + plane);
      occupancy = peak - center_level - front;
      beat.occupied_value = occupancy[ocd_pkg::OCC_W-1:0];
      beat.last_voxel = (c + 1 >= plane * d);
      expected_occupancy.insert(expected_occupancy.size(), beat);
      if (beat.last_voxel) begin
         restart_volume();
         volumes_closed++;
         return;
      end
      ctr_x++;
      if (ctr_x >= w) begin
         ctr_x = 0;
         ctr_y++;
         if (ctr_y >= h) begin
            ctr_y = 0;
            ctr_z++;
         end
      end
   endfunction

   function automatic void predict_occupancy(ocd_pkg::req_type item);
      int unsigned w, h, d, plane, p;
      logic [VW-1:0] front;
      active_dims(w, h, d);
      plane = w * h;
      if (voxels_in < plane * d) begin
         // a flush inside the volume changes nothing
         if (item.flush) return;
         p = voxels_in;
         empty_window[p % WINDOW_CAP] = item.empty_value;
         // the center's frontier must be read before its slot is reused
         front = frontier_line[(p + PLANE_CAP - plane) % PLANE_CAP];
         frontier_line[p % PLANE_CAP] = item.frontier_value;
         voxels_in = p + 1;
         if (p >= plane) emit_occupancy(front);
      end else begin
         // volume complete: any beat drains one delayed result
         emit_occupancy(frontier_line[(ctr_x + ctr_y * w + ctr_z * plane) % PLANE_CAP]);
      end
   endfunction

   function automatic ocd_pkg::req_type make_beat(logic [VW-1:0] empty_level,
                                                  frontier_level, logic flush);
      ocd_pkg::req_type item;
      item.empty_value    = empty_level;
      item.frontier_value = frontier_level;
      item.flush          = flush;
      return item;
   endfunction

   function automatic logic [VW-1:0] random_level();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return VW'($urandom_range(255));
      endcase
   endfunction

   // 7-bit extent with random upper bits, sometimes zero or past the maximum
   function automatic logic [CDW-1:0] random_extent(int unsigned small_hi, bit allow_wide);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return {4'($urandom_range(15)), 7'd0};
      if (allow_wide && roll < 12) return {4'($urandom_range(15)), 7'($urandom_range(127, 65))};
      return {4'($urandom_range(15)), 7'($urandom_range(small_hi, 1))};
   endfunction

   task automatic note_failure(string msg);
      if (failures < REPORT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
      failures++;
   endtask

   task automatic send_beat(ocd_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_occupancy(item);
      beats_sent++;
   endtask

   task automatic write_csr(logic [CIW-1:0] idx, logic [CDW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      latch_register(idx, value);
      csr_writes++;
   endtask

   task automatic program_volume(logic [CDW-1:0] w, h, d);
      write_csr(ocd_pkg::REG_WIDTH, w);
      write_csr(ocd_pkg::REG_HEIGHT, h);
      write_csr(ocd_pkg::REG_DEPTH, d);
      csr_wr_en <= 1'b0;
   endtask

   // drop valid and let every owed result come back before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_occupancy.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_voxel();
      if ($urandom_range(99) < 8) send_beat(make_beat(random_level(), random_level(), 1'b1));
      send_beat(make_beat(random_level(), random_level(), 1'b0));
      stream_items++;
   endtask

   task automatic send_drain();
      send_beat(make_beat(random_level(), random_level(), 1'($urandom_range(1))));
      stream_items++;
   endtask

   task automatic finish_volume();
      int unsigned w, h, d, closed_at;
      closed_at = volumes_closed;
      while (volumes_closed == closed_at) begin
         active_dims(w, h, d);
         if (voxels_in < w * h * d) send_voxel();
         else send_drain();
      end
   endtask

   task automatic run_volume(logic [CDW-1:0] w, h, d);
      wait_drained();
      program_volume(w, h, d);
      finish_volume();
   endtask

   task automatic test_directed_extremes();
      ocd_pkg::req_type script [$];
      send_idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      program_volume(11'd2, 11'd2, 11'd2);
      // first result is +255, second -255; a flush mid-volume, a voxel as drain
      script = '{make_beat(8'd0, 8'd0, 1'b0), make_beat(8'd255, 8'd255, 1'b0),
                 make_beat(8'd17, 8'd200, 1'b0), make_beat(8'd99, 8'd99, 1'b1),
                 make_beat(8'd128, 8'd1, 1'b0), make_beat(8'd255, 8'd0, 1'b0),
                 make_beat(8'd0, 8'd255, 1'b0), make_beat(8'd64, 8'd64, 1'b0),
                 make_beat(8'd3, 8'd254, 1'b0), make_beat(8'd255, 8'd255, 1'b0),
                 make_beat(8'd0, 8'd0, 1'b1), make_beat(8'd255, 8'd255, 1'b1),
                 make_beat(8'd170, 8'd85, 1'b1)};
      foreach (script[i]) send_beat(script[i]);
      wait_drained();
      // single plane: in-plane cross only
      program_volume(11'd2, 11'd2, 11'd1);
      script = '{make_beat(8'd0, 8'd0, 1'b0), make_beat(8'd0, 8'd128, 1'b0),
                 make_beat(8'd200, 8'd255, 1'b0), make_beat(8'd255, 8'd1, 1'b0),
                 make_beat(8'd85, 8'd170, 1'b1), make_beat(8'd7, 8'd7, 1'b0),
                 make_beat(8'd0, 8'd0, 1'b1), make_beat(8'd255, 8'd255, 1'b1)};
      foreach (script[i]) send_beat(script[i]);
   endtask

   task automatic test_register_limits();
      send_idle_pct = 21;
      stall_pct = 21;
      run_volume(11'd0, 11'd0, 11'd0);           // zeros read as one
      run_volume(11'h7FF, 11'd1, 11'd0);         // width masks to 127, clamps to 64
      run_volume(11'd1, 11'h7FF, 11'd2);
      run_volume(11'd2, 11'd1, 11'd3);
   endtask

   task automatic test_restart_mid_volume();
      send_idle_pct = 0;
      stall_pct = 65;
      wait_drained();
      program_volume(11'd3, 11'd3, 11'd3);
      repeat (14) send_voxel();
      // sender holds off until everything owed so far is back
      wait_drained();
      write_csr(REG_SPARE, 11'($urandom_range(2047)));
      csr_wr_en <= 1'b0;
      finish_volume();
      repeat (11) send_voxel();
      wait_drained();
      program_volume(11'd2, 11'd3, 11'd2);       // partial volume is abandoned
      finish_volume();
   endtask

   task automatic test_random_volumes(int unsigned idle, stall, target);
      int unsigned start, roll, w, h, d;
      logic [CDW-1:0] w_data, h_data, d_data;
      send_idle_pct = idle;
      stall_pct = stall;
      start = stream_items;
      while (stream_items - start < target) begin
         w_data = random_extent(8, 1'b1);
         w = dim_used(w_data[WREG_W-1:0], ocd_pkg::MAX_WIDTH_DEF);
         h_data = random_extent((w > 8) ? 2 : 6, w == 1);
         h = dim_used(h_data[HREG_W-1:0], ocd_pkg::MAX_HEIGHT_DEF);
         if ($urandom_range(9) == 0) d_data = '0;
         else d_data = CDW'((w * h > 64) ? $urandom_range(2, 1) : $urandom_range(4, 1));
         roll = $urandom_range(99);
         if (roll < 15 && voxels_in == 0) begin
            finish_volume();                     // next volume starts with no write
         end else begin
            wait_drained();
            program_volume(w_data, h_data, d_data);
            if (roll < 30) begin
               active_dims(w, h, d);
               repeat ($urandom_range(w * h * d - 1)) send_voxel();
            end else begin
               finish_volume();
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_occupancy
      ocd_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_occupancy.size() == 0) begin
               note_failure($sformatf("unexpected beat value %0d last %b",
                                      rsp_data.occupied_value, rsp_data.last_voxel));
            end else begin
               want = expected_occupancy.pop_front();
               if (rsp_data.occupied_value !== want.occupied_value ||
                   rsp_data.last_voxel !== want.last_voxel) begin
                  note_failure($sformatf("value exp %0d got %0d, last exp %b got %b",
                                         want.occupied_value, rsp_data.occupied_value,
                                         want.last_voxel, rsp_data.last_voxel));
               end
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  expected_occupancy.size());
         $display("occupied_from_cross_dilation_unit verification failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_register_limits();
      test_restart_mid_volume();
      test_random_volumes(0, 0, 70);
      test_random_volumes(65, 0, 70);
      test_random_volumes(0, 65, 70);
      test_random_volumes(21, 21, 70);
      wait_drained();
      $display("checked %0d occupancy results from %0d beats over %0d complete volumes",
               results_checked, beats_sent, volumes_closed);
      $display("%0d register writes, shapes from 1x1x1 up to 64-voxel rows and columns, %0d failures",
               csr_writes, failures);
      if (failures == 0) begin
         $display("occupied_from_cross_dilation_unit verification clean");
      end else begin
         $display("occupied_from_cross_dilation_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== occupied_from_cross_dilation_unit.f =====
design/ocd_pkg.sv
design/ocd_ram.sv
design/occupied_from_cross_dilation_unit.sv
tb/sv/tb_occupied_from_cross_dilation_unit.sv
